@@ hdl/rrg_pkg.sv @@
// Shared constants, types and helper functions for the RANROT-B generator.
package rrg_pkg;

	localparam int unsigned WORD_W   = 32;
	localparam int unsigned FRAC_W   = 23;
	localparam int unsigned RING_LEN = 17;
	localparam int unsigned PTR_W    = $clog2(RING_LEN);
	localparam int unsigned ROT_LAG  = 13;
	localparam int unsigned ROT_LEAD = 9;

	localparam logic [WORD_W-1:0] LCG_MUL   = 32'd2891336453;
	localparam logic [WORD_W-1:0] RESET_SEED = 32'd1;
	localparam logic [PTR_W-1:0]  LEAD_START = PTR_W'(0);
	localparam logic [PTR_W-1:0]  LAG_START  = PTR_W'(10);
	localparam logic [PTR_W-1:0]  PTR_LAST   = PTR_W'(RING_LEN - 1);

	localparam logic CMD_RESEED = 1'b0;
	localparam logic CMD_DRAW   = 1'b1;

	typedef enum logic [1:0] {
		ST_FILL,
		ST_IDLE,
		ST_WRITE
	} rrg_state_t;

	typedef struct packed {
		logic accept;     // count this input beat
		logic load_seed;  // start a reseed from the beat's seed
		logic fill_step;  // one congruential step into the ring
		logic rd_en;      // read lead and lag words
		logic draw_wr;    // write back the drawn word and load the output
	} rrg_cmd_t;

	typedef struct packed {
		logic fill_last;
		logic out_free;
	} rrg_status_t;

	function automatic logic [WORD_W-1:0] rotl_lag(input logic [WORD_W-1:0] v);
		return (v << ROT_LAG) | (v >> (WORD_W - ROT_LAG));
	endfunction

	function automatic logic [WORD_W-1:0] rotl_lead(input logic [WORD_W-1:0] v);
		return (v << ROT_LEAD) | (v >> (WORD_W - ROT_LEAD));
	endfunction

	function automatic logic [PTR_W-1:0] step_down(input logic [PTR_W-1:0] p);
		return (p == '0) ? PTR_LAST : PTR_W'(p - PTR_W'(1));
	endfunction

endpackage

@@ hdl/rrg_ctrl.sv @@
// Sequencer for the generator: reset fill, reseed sweep and the draw's read and write steps.
module rrg_ctrl import rrg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        command,
	input  rrg_status_t status,
	output rrg_cmd_t    cmd
);

	rrg_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FILL;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_FILL: begin
				cmd.fill_step = 1'b1;
				if (status.fill_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (command == CMD_RESEED) begin
						cmd.load_seed = 1'b1;
						state_d       = ST_FILL;
					end else begin
						cmd.rd_en = 1'b1;
						state_d   = ST_WRITE;
					end
				end
			end
			ST_WRITE: begin
				// wait here while the previous result is still held
				if (status.out_free) begin
					cmd.draw_wr = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_FILL;
			end
		endcase
	end

endmodule

@@ hdl/rrg_dp.sv @@
// Datapath: ring memory, pointers, congruential filler, draw adder, output register.
module rrg_dp import rrg_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  rrg_cmd_t            cmd,
	output rrg_status_t         status,
	input  logic [WORD_W-1:0]   seed,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [WORD_W-1:0]   random_word,
	output logic [FRAC_W-1:0]   unit_fraction
);

	logic [WORD_W-1:0] ring_mem [RING_LEN];
	logic [WORD_W-1:0] lead_rd_q, lag_rd_q;
	logic [PTR_W-1:0]  lead_q, lag_q, fill_idx_q;
	logic [WORD_W-1:0] count_q, lcg_q;
	logic [WORD_W-1:0] count_next, seed_eff, lcg_next, draw_word;
	logic              out_valid_q;
	logic [WORD_W-1:0] word_q;
	logic              mem_we;
	logic [PTR_W-1:0]  mem_wa;
	logic [WORD_W-1:0] mem_wd;

	assign count_next = count_q + WORD_W'(1);
	assign seed_eff   = (seed == '0) ? count_next : seed;
	assign lcg_next   = lcg_q * LCG_MUL + WORD_W'(1);
	assign draw_word  = rotl_lag(lag_rd_q) + rotl_lead(lead_rd_q);

	assign mem_we = cmd.fill_step | cmd.draw_wr;
	assign mem_wa = cmd.fill_step ? fill_idx_q : lead_q;
	assign mem_wd = cmd.fill_step ? lcg_next : draw_word;

	// ring: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (mem_we) begin
			ring_mem[mem_wa] <= mem_wd;
		end
		if (cmd.rd_en) begin
			lead_rd_q <= ring_mem[lead_q];
			lag_rd_q  <= ring_mem[lag_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			lcg_q      <= RESET_SEED;
			fill_idx_q <= '0;
			lead_q     <= LEAD_START;
			lag_q      <= LAG_START;
		end else begin
			if (cmd.accept) begin
				count_q <= count_next;
			end
			if (cmd.load_seed) begin
				lcg_q      <= seed_eff;
				fill_idx_q <= '0;
				lead_q     <= LEAD_START;
				lag_q      <= LAG_START;
			end else if (cmd.fill_step) begin
				lcg_q      <= lcg_next;
				fill_idx_q <= (fill_idx_q == PTR_LAST) ? '0 : PTR_W'(fill_idx_q + PTR_W'(1));
			end
			if (cmd.draw_wr) begin
				lead_q <= step_down(lead_q);
				lag_q  <= step_down(lag_q);
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.draw_wr) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.draw_wr) begin
			word_q <= draw_word;
		end
	end

	assign status.fill_last = (fill_idx_q == PTR_LAST);
	assign status.out_free  = !out_valid_q || !out_stall;

	assign out_valid     = out_valid_q;
	assign random_word   = word_q;
	assign unit_fraction = word_q[WORD_W-1 -: FRAC_W];

`ifndef SYNTHESIS
	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(lead_q <= PTR_LAST) && (lag_q <= PTR_LAST) && (fill_idx_q <= PTR_LAST))
		else $error("ring pointer out of range");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		((PTR_W+1)'(lag_q) == (PTR_W+1)'(lead_q) + (PTR_W+1)'(LAG_START)) ||
		((PTR_W+1)'(lag_q) + (PTR_W+1)'(RING_LEN) ==
			(PTR_W+1)'(lead_q) + (PTR_W+1)'(LAG_START)))
		else $error("lead and lag pointers lost their spacing");

	a_out_from_draw: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.draw_wr))
		else $error("result appeared without a draw");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.draw_wr |-> (!out_valid_q || !out_stall))
		else $error("held result overwritten");
`endif

endmodule

@@ hdl/ranrot_random_generator.sv @@
// RANROT-B random generator: 17-word ring with lags 0 and 10.
//
// Input channel (in_valid / in_stall, command, seed): command 1 draws one
// word, command 0 reseeds the ring from seed; a zero seed is replaced by
// the running count of input beats. Every input beat bumps that count.
// Output channel (out_valid / out_stall, random_word, unit_fraction): one
// beat per draw, none per reseed. unit_fraction is the word's top 23 bits,
// a fraction in [0,1) with 23 fractional bits.
// A draw first does the ring memory's registered read of the lead and
// lag words, then the add, write-back and output load. The result is valid
// in the cycle after the draw's write step. A reseed holds in_stall high
// while it makes one congruential step (one 32x32 multiply) per ring word.
// After reset the ring is filled from seed 1 by the same sweep;
// in_stall stays high until it ends. Pointers reset to 0 and 10, count to 0.
// A stalled result is held; a new item is still taken while it waits, but
// a draw finishes only once the output register is free.
module ranrot_random_generator import rrg_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                command,
	input  logic [WORD_W-1:0]   seed,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [WORD_W-1:0]   random_word,
	output logic [FRAC_W-1:0]   unit_fraction
);

	rrg_cmd_t    cmd;
	rrg_status_t status;

	rrg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.command  (command),
		.status   (status),
		.cmd      (cmd)
	);

	rrg_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.seed          (seed),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.random_word   (random_word),
		.unit_fraction (unit_fraction)
	);

endmodule

@@ verif/tb_ranrot_random_generator.sv @@
// Self-checking testbench for the RANROT-B random generator: scoreboard plus drivers.
module tb_ranrot_random_generator import rrg_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 20;
	localparam int RANDOM_BEATS   = 1250;

	// Keeps its own copy of the ring and predicts every drawn word.
	class ranrot_scoreboard;
		logic [WORD_W-1:0] ring [RING_LEN];
		logic [PTR_W-1:0]  lead_idx;
		logic [PTR_W-1:0]  lag_idx;
		logic [WORD_W-1:0] beat_count;
		logic [WORD_W-1:0] word_q [$];
		int                errors;

		function new();
			refill(RESET_SEED);
			beat_count = '0;
			errors     = 0;
		endfunction

		function automatic logic [WORD_W-1:0] rotate(logic [WORD_W-1:0] v, int k);
			return (v << k) | (v >> (WORD_W - k));
		endfunction

		function automatic logic [PTR_W-1:0] wrap_down(logic [PTR_W-1:0] p);
			return (p == 0) ? PTR_W'(RING_LEN - 1) : p - PTR_W'(1);
		endfunction

		function void refill(logic [WORD_W-1:0] s);
			for (int i = 0; i < RING_LEN; i++) begin
				s = s * LCG_MUL + WORD_W'(1);
				ring[i] = s;
			end
			lead_idx = LEAD_START;
			lag_idx  = LAG_START;
		endfunction

		function void note_input(logic cmd, logic [WORD_W-1:0] s);
			logic [WORD_W-1:0] word;
			beat_count = beat_count + WORD_W'(1);
			if (cmd == CMD_RESEED) begin
				// zero seed falls back to the running beat count
				refill((s == '0) ? beat_count : s);
			end else begin
				word = rotate(ring[lag_idx], ROT_LAG) + rotate(ring[lead_idx], ROT_LEAD);
				ring[lead_idx] = word;
				lead_idx = wrap_down(lead_idx);
				lag_idx  = wrap_down(lag_idx);
				word_q.push_back(word);
			end
		endfunction

		task report(string msg);
			$display("MISMATCH @%0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_result(logic [WORD_W-1:0] word, logic [FRAC_W-1:0] frac);
			logic [WORD_W-1:0] want;
			if (word_q.size() == 0) begin
				report($sformatf("unexpected result word %h", word));
			end else begin
				want = word_q.pop_front();
				if (word !== want)
					report($sformatf("random_word %h, expected %h", word, want));
				if (frac !== want[WORD_W-1 -: FRAC_W])
					report($sformatf("unit_fraction %h, expected %h", frac,
						want[WORD_W-1 -: FRAC_W]));
			end
		endtask

		function int pending();
			return word_q.size();
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic              command;
	logic [WORD_W-1:0] seed;
	logic              out_valid;
	logic              out_stall;
	logic [WORD_W-1:0] random_word;
	logic [FRAC_W-1:0] unit_fraction;

	ranrot_scoreboard sb;
	int idle_pct;
	int stall_pct;
	int quiet_cycles;

	ranrot_random_generator uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.command       (command),
		.seed          (seed),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.random_word   (random_word),
		.unit_fraction (unit_fraction)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	// Monitor: both channels sampled at the edge, plus the no-progress watchdog.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note_input(command, seed);
			if (out_valid && !out_stall)
				sb.check_result(random_word, unit_fraction);
		end
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("ranrot_random_generator test failed");
			$finish;
		end
	end

	task send_beat(logic cmd, logic [WORD_W-1:0] s);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		command  <= cmd;
		seed     <= s;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task send_random();
		logic [WORD_W-1:0] s;
		if ($urandom_range(0, 19) == 0) begin
			s = ($urandom_range(0, 3) == 0) ? '0 : WORD_W'($urandom);
			send_beat(CMD_RESEED, s);
		end else begin
			send_beat(CMD_DRAW, WORD_W'($urandom));
		end
	endtask

	initial begin
		sb           = new();
		idle_pct     = 0;
		stall_pct    = 0;
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		command   <= CMD_DRAW;
		seed      <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// directed: draw from reset ring, zero seeds back to back, extreme seeds,
		// enough draws to wrap both pointers through zero
		send_beat(CMD_DRAW, '0);
		send_beat(CMD_RESEED, '0);
		send_beat(CMD_RESEED, '0);
		send_beat(CMD_DRAW, '1);
		send_beat(CMD_RESEED, '1);
		repeat (18) send_beat(CMD_DRAW, '0);
		send_beat(CMD_RESEED, 32'h8000_0000);
		send_beat(CMD_DRAW, '0);

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 77; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 77; end
				default: begin idle_pct = 35; stall_pct = 35; end
			endcase
			repeat (RANDOM_BEATS / 4) send_random();
		end
		in_valid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("ranrot_random_generator test passed");
		else
			$display("ranrot_random_generator test failed");
		$finish;
	end

endmodule

@@ filelist.f @@
hdl/rrg_pkg.sv
hdl/rrg_ctrl.sv
hdl/rrg_dp.sv
hdl/ranrot_random_generator.sv
verif/tb_ranrot_random_generator.sv
